>>> src/ksat_pkg.sv
// Shared types, codes and helper functions of the keyed signal accumulate table.
package ksat_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REPORT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_MERGED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_SATURATED = 3'd3;
  localparam logic [2:0] ST_AVERAGE   = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  localparam int DIVIDEND_W = 20;
  localparam int DIVISOR_W  = 8;

  typedef struct packed {
    logic [1:0]         mode;
    logic [47:0]        mac_address;
    logic signed [7:0]  signal_dbm;
    logic signed [7:0]  noise_dbm;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         entry_index;
    logic [47:0]        entry_address;
    logic signed [11:0] avg_signal;
    logic signed [11:0] avg_noise;
    logic [7:0]         samples;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [47:0]        key;
    logic signed [15:0] signal_sum;
    logic signed [15:0] noise_sum;
    logic [7:0]         count;
  } entry_t;

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

  function automatic entry_t fresh_entry(input cmd_t c);
    entry_t e;
    e.key        = c.mac_address;
    e.signal_sum = sext8(c.signal_dbm);
    e.noise_sum  = sext8(c.noise_dbm);
    e.count      = 8'd1;
    return e;
  endfunction

  function automatic entry_t merge_entry(input entry_t e, input cmd_t c);
    entry_t m;
    m.key        = e.key;
    m.signal_sum = e.signal_sum + sext8(c.signal_dbm);
    m.noise_sum  = e.noise_sum + sext8(c.noise_dbm);
    m.count      = e.count + 8'd1;
    return m;
  endfunction

  function automatic logic [DIVIDEND_W-1:0] scaled_mag(input logic [15:0] s);
    logic [15:0] mag;
    mag = s[15] ? (16'd0 - s) : s;
    return {mag, 4'b0000};
  endfunction

  function automatic logic [11:0] apply_sign(input logic neg, input logic [11:0] q);
    return neg ? (12'd0 - q) : q;
  endfunction

  function automatic res_t make_res(input logic [2:0] status, input logic [5:0] index,
                                    input logic [47:0] address, input logic [11:0] avg_s,
                                    input logic [11:0] avg_n, input logic [7:0] samples,
                                    input logic last);
    res_t r;
    r.status        = status;
    r.entry_index   = index;
    r.entry_address = address;
    r.avg_signal    = avg_s;
    r.avg_noise     = avg_n;
    r.samples       = samples;
    r.last          = last;
    return r;
  endfunction

endpackage

>>> src/ksat_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ksat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/ksat_div.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
module ksat_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ksat_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [ksat_pkg::DIVISOR_W-1:0]   divisor,
  output logic                             done,
  output logic [ksat_pkg::DIVIDEND_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(ksat_pkg::DIVIDEND_W);

  logic                            busy;
  logic [STEP_W-1:0]               step;
  logic [ksat_pkg::DIVISOR_W-1:0]  rem;
  logic [ksat_pkg::DIVISOR_W-1:0]  dsr;
  logic [ksat_pkg::DIVISOR_W:0]    trial;
  logic [ksat_pkg::DIVISOR_W:0]    diff;

  assign trial = {rem, quotient[ksat_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        quotient <= dividend;
        rem      <= '0;
        dsr      <= divisor;
      end else if (busy) begin
        if (!diff[ksat_pkg::DIVISOR_W]) begin
          rem      <= diff[ksat_pkg::DIVISOR_W-1:0];
          quotient <= {quotient[ksat_pkg::DIVIDEND_W-2:0], 1'b1};
        end else begin
          rem      <= trial[ksat_pkg::DIVISOR_W-1:0];
          quotient <= {quotient[ksat_pkg::DIVIDEND_W-2:0], 1'b0};
        end
        step <= step + STEP_W'(1);
        if (step == STEP_W'(ksat_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/keyed_signal_accumulate_table_unit.sv
// Top level: MAC-keyed signal and noise accumulation table with averaged reports.
// Add: an empty table is written from idle; else the filled entries are searched for the key.
// Report: entries are averaged in turn by the 20-step divider; empty table or clear: one word.
// One word is worked on at a time; a new word is taken while the last result waits downstream.
// Synchronous reset empties the table at once; no clearing pass over the RAM is needed.
module keyed_signal_accumulate_table_unit #(
  parameter int TABLE_DEPTH = 32,
  parameter int MAX_SAMPLES = 255
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  ksat_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output ksat_pkg::res_t  res
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_RLOAD = 3'd3;
  localparam logic [2:0] S_RDIV  = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] idx;
  ksat_pkg::cmd_t   cmd_q;
  ksat_pkg::res_t   pend;
  ksat_pkg::entry_t ent;
  logic             div_start;

  logic             cmd_fire;
  logic             res_free;
  logic [IDX_W-1:0] idx_inc;
  logic             idx_is_last;
  logic             hit;
  logic             saturated;
  logic             full;
  logic             div_done;
  logic             noi_done;
  logic [ksat_pkg::DIVIDEND_W-1:0] sig_quo;
  logic [ksat_pkg::DIVIDEND_W-1:0] noi_quo;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  ksat_pkg::entry_t wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  ksat_pkg::entry_t rd_data;
  ksat_pkg::entry_t merged;

  assign cmd_ready   = (state == S_IDLE);
  assign cmd_fire    = cmd_valid && cmd_ready;
  assign res_free    = !res_valid || res_ready;
  assign idx_inc     = idx + IDX_W'(1);
  assign idx_is_last = ((CNT_W'(idx) + CNT_W'(1)) == entry_count);
  assign hit         = (rd_data.key == cmd_q.mac_address);
  assign saturated   = (rd_data.count >= 8'(MAX_SAMPLES));
  assign full        = (entry_count == CNT_W'(TABLE_DEPTH));
  assign merged      = ksat_pkg::merge_entry(rd_data, cmd_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = merged;
    rd_en   = 1'b0;
    rd_addr = idx_inc;
    case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (cmd_fire && entry_count != '0 &&
            (cmd.mode == ksat_pkg::MODE_ADD || cmd.mode == ksat_pkg::MODE_REPORT)) begin
          rd_en = 1'b1;
        end
        if (cmd_fire && cmd.mode == ksat_pkg::MODE_ADD && entry_count == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = ksat_pkg::fresh_entry(cmd);
        end
      end
      S_LOOK: begin
        rd_en = !idx_is_last;
        if (hit) begin
          wr_en = !saturated;
        end else if (idx_is_last && !full) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(entry_count);
          wr_data = ksat_pkg::fresh_entry(cmd_q);
        end
      end
      S_EMIT: begin
        rd_en = res_free && !pend.last && (cmd_q.mode == ksat_pkg::MODE_REPORT);
      end
      default: begin
      end
    endcase
  end

  ksat_ram #(
    .WIDTH($bits(ksat_pkg::entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ksat_div u_div_signal (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ksat_pkg::scaled_mag(ent.signal_sum)),
    .divisor  (ent.count),
    .done     (div_done),
    .quotient (sig_quo)
  );

  ksat_div u_div_noise (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ksat_pkg::scaled_mag(ent.noise_sum)),
    .divisor  (ent.count),
    .done     (noi_done),
    .quotient (noi_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      res_valid   <= 1'b0;
      div_start   <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            cmd_q <= cmd;
            idx   <= '0;
            case (cmd.mode)
              ksat_pkg::MODE_ADD: begin
                if (entry_count == '0) begin
                  pend <= ksat_pkg::make_res(ksat_pkg::ST_INSERTED, 6'd0, cmd.mac_address,
                                             12'd0, 12'd0, 8'd1, 1'b1);
                  entry_count <= CNT_W'(1);
                  state       <= S_EMIT;
                end else begin
                  state <= S_LOOK;
                end
              end
              ksat_pkg::MODE_REPORT: begin
                if (entry_count == '0) begin
                  pend  <= ksat_pkg::make_res(ksat_pkg::ST_EMPTY, 6'd0, 48'd0,
                                              12'd0, 12'd0, 8'd0, 1'b1);
                  state <= S_EMIT;
                end else begin
                  state <= S_RLOAD;
                end
              end
              ksat_pkg::MODE_CLEAR: begin
                entry_count <= '0;
                pend  <= ksat_pkg::make_res(ksat_pkg::ST_CLEARED, 6'd0, 48'd0,
                                            12'd0, 12'd0, 8'd0, 1'b1);
                state <= S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_LOOK: begin
          if (hit) begin
            if (saturated) begin
              pend <= ksat_pkg::make_res(ksat_pkg::ST_SATURATED, 6'(idx), cmd_q.mac_address,
                                         12'd0, 12'd0, rd_data.count, 1'b1);
            end else begin
              pend <= ksat_pkg::make_res(ksat_pkg::ST_MERGED, 6'(idx), cmd_q.mac_address,
                                         12'd0, 12'd0, merged.count, 1'b1);
            end
            state <= S_EMIT;
          end else if (idx_is_last) begin
            if (full) begin
              pend <= ksat_pkg::make_res(ksat_pkg::ST_FULL, 6'd0, cmd_q.mac_address,
                                         12'd0, 12'd0, 8'd0, 1'b1);
            end else begin
              pend <= ksat_pkg::make_res(ksat_pkg::ST_INSERTED, 6'(entry_count),
                                         cmd_q.mac_address, 12'd0, 12'd0, 8'd1, 1'b1);
              entry_count <= entry_count + CNT_W'(1);
            end
            state <= S_EMIT;
          end else begin
            idx <= idx_inc;
          end
        end
        S_RLOAD: begin
          ent       <= rd_data;
          div_start <= 1'b1;
          state     <= S_RDIV;
        end
        S_RDIV: begin
          if (div_done && noi_done) begin
            pend <= ksat_pkg::make_res(ksat_pkg::ST_AVERAGE, 6'(idx), ent.key,
                                       ksat_pkg::apply_sign(ent.signal_sum[15], sig_quo[11:0]),
                                       ksat_pkg::apply_sign(ent.noise_sum[15], noi_quo[11:0]),
                                       ent.count, idx_is_last);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_free) begin
            res       <= pend;
            res_valid <= 1'b1;
            if (pend.last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx_inc;
              state <= S_RLOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/ksat_chk.sv
// Port-level checker for the accumulate table, bound to the top level.
module ksat_chk (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_ready,
  input ksat_pkg::res_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("Result word changed or dropped while stalled.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.status <= ksat_pkg::ST_CLEARED)
    else $error("Result word carries an unused status code.");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ksat_pkg::ST_AVERAGE |-> res.last)
    else $error("Single-result status without the last marker.");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ksat_pkg::ST_EMPTY || res.status == ksat_pkg::ST_CLEARED ||
                  res.status == ksat_pkg::ST_FULL)
    |-> res.samples == 8'd0 && res.avg_signal == 12'sd0 && res.avg_noise == 12'sd0
        && res.entry_index == 6'd0)
    else $error("Empty, cleared or full result carries nonzero fields.");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ksat_pkg::ST_INSERTED |-> res.samples == 8'd1)
    else $error("Inserted entry does not report a single sample.");

endmodule

bind keyed_signal_accumulate_table_unit ksat_chk u_ksat_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
